// ----- hw/rtl/mscc_pkg.sv -----
// ----------------------------------------------------------------------------
// mscc_pkg
// Shared types and constants of the small MIPS subset core: item layouts,
// action codes, opcodes, ALU codes and memory sizes.
// ----------------------------------------------------------------------------
package mscc_pkg;

  // data memory size in words, a power of two
  localparam int DATA_WORDS = 16384;
  localparam int DMEM_AW    = $clog2(DATA_WORDS);

  // register file
  localparam int NUM_REGS = 32;
  localparam int REG_AW   = $clog2(NUM_REGS);

  // stream widths (whole bytes) and the word index width
  localparam int IN_W  = 88;
  localparam int OUT_W = 136;
  localparam int WIDX_W = 14;

  // request kinds carried on tuser
  typedef enum logic [1:0] {
    ACT_EXEC  = 2'd0,
    ACT_WRMEM = 2'd1,
    ACT_RDMEM = 2'd2,
    ACT_RDREG = 2'd3
  } action_t;

  // opcodes
  localparam logic [5:0] OP_RTYPE = 6'd0;
  localparam logic [5:0] OP_J     = 6'd2;
  localparam logic [5:0] OP_JAL   = 6'd3;
  localparam logic [5:0] OP_BEQ   = 6'd4;
  localparam logic [5:0] OP_LW    = 6'd35;
  localparam logic [5:0] OP_SW    = 6'd43;

  // alu codes
  localparam logic [2:0] ALU_ADD = 3'd1;
  localparam logic [2:0] ALU_SUB = 3'd3;
  localparam logic [2:0] ALU_AND = 3'd4;
  localparam logic [2:0] ALU_OR  = 3'd5;
  localparam logic [2:0] ALU_NOR = 3'd7;

  localparam logic [31:0] HALT_WORD = 32'hFFFF_FFFF;
  localparam logic [31:0] PC_STEP   = 32'd4;

  // input request layout, last member in the lowest bits
  typedef struct packed {
    logic [4:0]        pad;
    logic [4:0]        register_index;
    logic [31:0]       load_value;
    logic [WIDX_W-1:0] word_index;
    logic [31:0]       instruction;
  } in_item_t;

  // result layout, last member in the lowest bits
  typedef struct packed {
    logic [31:0] read_value;
    logic        branch_taken;
    logic [31:0] dest_value;
    logic [4:0]  dest_register;
    logic        reg_written;
    logic [31:0] alu_value;
    logic        halted;
    logic [31:0] next_pc;
  } out_item_t;

endpackage

// ----- hw/rtl/mscc_ram.sv -----
// ----------------------------------------------------------------------------
// mscc_ram
// Generic single write port, single read port RAM with registered read.
// A read at the address being written returns the old word.
// ----------------------------------------------------------------------------
module mscc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hw/rtl/mips_subset_single_cycle_core_unit.sv -----
// ----------------------------------------------------------------------------
// mips_subset_single_cycle_core_unit
// Small MIPS subset core driven one request at a time by a host.
// ----------------------------------------------------------------------------
// The host sends requests on the in_ stream: tuser selects execute, write
// data word, read data word or read register; tdata carries the instruction
// word fetched at the current pc and the other operands. Each request gives
// one result on the out_ stream: next pc, halt flag, ALU result register,
// register writeback and branch flags, and the value read.
// Loads also pass through the load writeback stage, because their data
// word is read in a second data memory access after the address is
// computed. Throughput: one request per cycle while the output is not
// stalled; an lw holds off the next request until its load stage is
// done. Register file and data memory reads issued at acceptance feed
// the execute step; writes meeting a read of the same entry are forwarded.
// Reset (rst_n low, synchronous) clears pc, the ALU result and the register
// file valid bits, so every register reads as zero; data memory contents
// stay undefined until written.
// When out_tready is low the result holds in the output register and one
// more request can be accepted and wait in the execute stage.
// ----------------------------------------------------------------------------
module mips_subset_single_cycle_core_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // instruction[31:0], word_index[45:32], load_value[77:46],
  // register_index[82:78], zero pad[87:83]
  input  logic [mscc_pkg::IN_W-1:0]  in_tdata,
  // action[1:0]
  input  logic [1:0]                 in_tuser,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // next_pc[31:0], halted[32], alu_value[64:33], reg_written[65],
  // dest_register[70:66], dest_value[102:71], branch_taken[103],
  // read_value[135:104]
  output logic [mscc_pkg::OUT_W-1:0] out_tdata
);

  localparam int AW  = mscc_pkg::DMEM_AW;
  localparam int RAW = mscc_pkg::REG_AW;

  // input unpacking
  mscc_pkg::in_item_t in_item;
  mscc_pkg::action_t  in_act;
  logic               in_fire;
  logic [mscc_pkg::WIDX_W+AW-1:0] in_widx_ext;
  logic [AW-1:0]      in_widx;

  assign in_item     = mscc_pkg::in_item_t'(in_tdata);
  assign in_act      = mscc_pkg::action_t'(in_tuser);
  assign in_fire     = in_tvalid && in_tready;
  assign in_widx_ext = {{AW{1'b0}}, in_item.word_index};
  assign in_widx     = in_widx_ext[AW-1:0];

  // architectural state
  logic [31:0]         pc_r, pc_nxt;
  logic [31:0]         alu_r, alu_nxt;
  logic [mscc_pkg::NUM_REGS-1:0] rf_vld_r, rf_vld_nxt;

  // execute stage
  logic                b_valid_r, b_valid_nxt;
  mscc_pkg::action_t   b_act_r;
  logic [31:0]         b_insn_r;
  logic [AW-1:0]       b_widx_r;
  logic [31:0]         b_lval_r;
  logic [RAW-1:0]      b_ra_r, b_rb_r;
  logic                rfa_hit_r, rfb_hit_r, rfa_vld_r, rfb_vld_r;
  logic [31:0]         rf_fwd_data_r;
  logic                dfwd_hit_r;
  logic [31:0]         dfwd_data_r;

  // load writeback stage
  logic                c_valid_r, c_valid_nxt;
  logic [31:0]         c_pc_r, c_alu_r;
  logic [RAW-1:0]      c_dst_r;

  // output register
  logic                out_valid_r, out_valid_nxt;
  mscc_pkg::out_item_t out_data_r, out_data_nxt;
  logic                out_free;

  // memory ports
  logic                rf_we;
  logic [RAW-1:0]      rf_waddr;
  logic [31:0]         rf_wdata;
  logic [RAW-1:0]      rf_raddr_a, rf_raddr_b;
  logic [31:0]         rfa_q, rfb_q;
  logic                dm_we, dm_re;
  logic [AW-1:0]       dm_waddr, dm_raddr;
  logic [31:0]         dm_wdata, dm_q;

  // execute results
  logic [5:0]          op;
  logic [RAW-1:0]      rd;
  logic [31:0]         imm_sx, ra_val, rb_val, opa, opb, pc4;
  logic                jtype, itype;
  logic [2:0]          aop;
  logic [31:0]         ex_pc, ex_alu, ex_rval, ex_dval;
  logic                ex_halt, ex_taken, ex_wr, ex_lw, ex_dm_we;
  logic [RAW-1:0]      ex_dst, dst;
  logic [AW-1:0]       ex_dm_addr;
  logic [31:0]         ex_dm_data;
  logic                b_done, c_done;

  assign out_free = !out_valid_r || out_tready;
  assign b_done   = b_valid_r && (ex_lw || out_free);
  assign c_done   = c_valid_r && out_free;
  assign in_tready = (!b_valid_r || (b_done && !ex_lw)) && (!c_valid_r || c_done);

  // register file reads issued at acceptance
  assign rf_raddr_a = (in_act == mscc_pkg::ACT_RDREG) ? in_item.register_index
                                                       : in_item.instruction[25:21];
  assign rf_raddr_b = in_item.instruction[20:16];

  // operand values with forwarding and reset valid bits
  always_comb begin
    if (b_ra_r == '0) begin
      ra_val = '0;
    end else if (rfa_hit_r) begin
      ra_val = rf_fwd_data_r;
    end else if (rfa_vld_r) begin
      ra_val = rfa_q;
    end else begin
      ra_val = '0;
    end
    if (b_rb_r == '0) begin
      rb_val = '0;
    end else if (rfb_hit_r) begin
      rb_val = rf_fwd_data_r;
    end else if (rfb_vld_r) begin
      rb_val = rfb_q;
    end else begin
      rb_val = '0;
    end
  end

  // instruction decode
  assign op     = b_insn_r[31:26];
  assign rd     = b_insn_r[15:11];
  assign imm_sx = {{16{b_insn_r[15]}}, b_insn_r[15:0]};
  assign jtype  = (op == mscc_pkg::OP_J) || (op == mscc_pkg::OP_JAL);
  assign itype  = (op != mscc_pkg::OP_RTYPE) && !jtype;
  assign pc4    = pc_r + mscc_pkg::PC_STEP;
  assign opa    = jtype ? 32'd0 : ra_val;
  assign opb    = itype ? imm_sx : (jtype ? 32'd0 : rb_val);

  always_comb begin
    if (op == mscc_pkg::OP_LW || op == mscc_pkg::OP_SW) begin
      aop = mscc_pkg::ALU_ADD;
    end else if (op == mscc_pkg::OP_RTYPE) begin
      aop = b_insn_r[2:0];
    end else begin
      aop = op[2:0];
    end
    if (op == mscc_pkg::OP_RTYPE) begin
      dst = rd;
    end else if (itype) begin
      dst = b_insn_r[20:16];
    end else begin
      dst = '0;
    end
  end

  // execute step
  always_comb begin
    ex_pc      = pc_r;
    ex_alu     = alu_r;
    ex_halt    = 1'b0;
    ex_taken   = 1'b0;
    ex_wr      = 1'b0;
    ex_dst     = '0;
    ex_dval    = '0;
    ex_rval    = '0;
    ex_lw      = 1'b0;
    ex_dm_we   = 1'b0;
    ex_dm_addr = b_widx_r;
    ex_dm_data = b_lval_r;
    case (b_act_r)
      mscc_pkg::ACT_WRMEM: begin
        ex_dm_we = 1'b1;
      end
      mscc_pkg::ACT_RDMEM: begin
        ex_rval = dfwd_hit_r ? dfwd_data_r : dm_q;
      end
      mscc_pkg::ACT_RDREG: begin
        ex_rval = ra_val;
      end
      default: begin
        if (b_insn_r == mscc_pkg::HALT_WORD) begin
          ex_halt = 1'b1;
        end else begin
          // next pc
          if (jtype) begin
            ex_pc = {pc4[31:28], b_insn_r[25:0], 2'b00};
          end else if (op == mscc_pkg::OP_BEQ && ra_val == rb_val) begin
            ex_pc    = pc4 + {imm_sx[29:0], 2'b00};
            ex_taken = 1'b1;
          end else begin
            ex_pc = pc4;
          end
          // alu
          case (aop)
            mscc_pkg::ALU_ADD: ex_alu = opa + opb;
            mscc_pkg::ALU_SUB: ex_alu = opa - opb;
            mscc_pkg::ALU_AND: ex_alu = opa & opb;
            mscc_pkg::ALU_OR:  ex_alu = opa | opb;
            mscc_pkg::ALU_NOR: ex_alu = ~(opa | opb);
            default:           ex_alu = alu_r;
          endcase
          // memory access
          ex_dm_addr = ex_alu[AW+1:2];
          ex_dm_data = rb_val;
          ex_dm_we   = (op == mscc_pkg::OP_SW);
          ex_lw      = (op == mscc_pkg::OP_LW);
          // writeback, loads finish in the next stage
          if (!(op == mscc_pkg::OP_SW || op == mscc_pkg::OP_J ||
                op == mscc_pkg::OP_BEQ) && dst != '0 && !ex_lw) begin
            ex_wr   = 1'b1;
            ex_dst  = dst;
            ex_dval = ex_alu;
          end
        end
      end
    endcase
  end

  // register file write port, execute and load stages never overlap
  always_comb begin
    if (c_done) begin
      rf_we    = (c_dst_r != '0);
      rf_waddr = c_dst_r;
      rf_wdata = dm_q;
    end else begin
      rf_we    = b_done && ex_wr;
      rf_waddr = ex_dst;
      rf_wdata = ex_dval;
    end
  end

  // data memory ports
  assign dm_we    = b_done && ex_dm_we;
  assign dm_waddr = ex_dm_addr;
  assign dm_wdata = ex_dm_data;
  assign dm_re    = (in_fire && in_act == mscc_pkg::ACT_RDMEM) || (b_done && ex_lw);
  assign dm_raddr = (b_valid_r && ex_lw) ? ex_dm_addr : in_widx;

  // next state of control and architectural registers
  always_comb begin
    pc_nxt        = pc_r;
    alu_nxt       = alu_r;
    rf_vld_nxt    = rf_vld_r;
    b_valid_nxt   = b_valid_r;
    c_valid_nxt   = c_valid_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (b_done) begin
      pc_nxt      = ex_pc;
      alu_nxt     = ex_alu;
      b_valid_nxt = 1'b0;
      if (ex_lw) begin
        c_valid_nxt = 1'b1;
      end else begin
        out_valid_nxt              = 1'b1;
        out_data_nxt.next_pc       = ex_pc;
        out_data_nxt.halted        = ex_halt;
        out_data_nxt.alu_value     = ex_alu;
        out_data_nxt.reg_written   = ex_wr;
        out_data_nxt.dest_register = ex_dst;
        out_data_nxt.dest_value    = ex_dval;
        out_data_nxt.branch_taken  = ex_taken;
        out_data_nxt.read_value    = ex_rval;
      end
    end
    if (c_done) begin
      c_valid_nxt                = 1'b0;
      out_valid_nxt              = 1'b1;
      out_data_nxt.next_pc       = c_pc_r;
      out_data_nxt.halted        = 1'b0;
      out_data_nxt.alu_value     = c_alu_r;
      out_data_nxt.reg_written   = (c_dst_r != '0);
      out_data_nxt.dest_register = c_dst_r;
      out_data_nxt.dest_value    = (c_dst_r != '0) ? dm_q : 32'd0;
      out_data_nxt.branch_taken  = 1'b0;
      out_data_nxt.read_value    = '0;
    end
    if (rf_we) begin
      rf_vld_nxt[rf_waddr] = 1'b1;
    end
    if (in_fire) begin
      b_valid_nxt = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= '0;
      alu_r       <= '0;
      rf_vld_r    <= '0;
      b_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      alu_r       <= alu_nxt;
      rf_vld_r    <= rf_vld_nxt;
      b_valid_r   <= b_valid_nxt;
      c_valid_r   <= c_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (in_fire) begin
      b_act_r       <= in_act;
      b_insn_r      <= in_item.instruction;
      b_widx_r      <= in_widx;
      b_lval_r      <= in_item.load_value;
      b_ra_r        <= rf_raddr_a;
      b_rb_r        <= rf_raddr_b;
      // writes landing at the same edge as the reads
      rfa_hit_r     <= rf_we && (rf_waddr == rf_raddr_a);
      rfb_hit_r     <= rf_we && (rf_waddr == rf_raddr_b);
      rf_fwd_data_r <= rf_wdata;
      rfa_vld_r     <= rf_vld_r[rf_raddr_a];
      rfb_vld_r     <= rf_vld_r[rf_raddr_b];
      dfwd_hit_r    <= dm_we && (dm_waddr == in_widx);
      dfwd_data_r   <= dm_wdata;
    end
    if (b_done && ex_lw) begin
      c_pc_r  <= ex_pc;
      c_alu_r <= ex_alu;
      c_dst_r <= dst;
    end
  end

  // register file, one copy per read port
  mscc_ram #(
    .WIDTH(32),
    .DEPTH(mscc_pkg::NUM_REGS)
  ) u_rf_a (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .re    (in_fire),
    .raddr (rf_raddr_a),
    .rdata (rfa_q)
  );

  mscc_ram #(
    .WIDTH(32),
    .DEPTH(mscc_pkg::NUM_REGS)
  ) u_rf_b (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .re    (in_fire),
    .raddr (rf_raddr_b),
    .rdata (rfb_q)
  );

  // data memory
  mscc_ram #(
    .WIDTH(32),
    .DEPTH(mscc_pkg::DATA_WORDS)
  ) u_dmem (
    .clk   (clk),
    .we    (dm_we),
    .waddr (dm_waddr),
    .wdata (dm_wdata),
    .re    (dm_re),
    .raddr (dm_raddr),
    .rdata (dm_q)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- hw/rtl/mscc_checker.sv -----
// ----------------------------------------------------------------------------
// mscc_checker
// Port-level checks of the result stream of the MIPS subset core.
// ----------------------------------------------------------------------------
module mscc_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [mscc_pkg::OUT_W-1:0] out_tdata
);

  mscc_pkg::out_item_t res;

  assign res = mscc_pkg::out_item_t'(out_tdata);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // halt leaves registers and pc flow alone
  a_halt: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res.halted |-> !res.reg_written && !res.branch_taken)
    else $error("halt with writeback or branch");

  // no writeback means empty destination fields
  a_nowr: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !res.reg_written |-> res.dest_register == '0 && res.dest_value == '0)
    else $error("destination fields set without a write");

  // register zero is never reported as written
  a_r0: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res.reg_written |-> res.dest_register != '0)
    else $error("write to register zero reported");

  // reset empties the output register
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind mips_subset_single_cycle_core_unit mscc_checker u_mscc_checker (.*);

// ----- sim/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the small MIPS subset core: a shadow copy of pc,
// register file, data memory and ALU result register predicts every result
// of the request stream, with random request gaps and output stalls.
// ----------------------------------------------------------------------------
module tb;
  import mscc_pkg::*;

  // shadow core state and the queue of predicted results
  class core_scoreboard;
    logic [31:0] gpr [NUM_REGS];
    logic [31:0] dmem [DATA_WORDS];
    bit          dmem_valid [DATA_WORDS];
    logic [31:0] pc_q;
    logic [31:0] alu_q;
    out_item_t   pending_results[$];
    int          errors;

    function new();
      foreach (gpr[i]) gpr[i] = '0;
      foreach (dmem_valid[i]) dmem_valid[i] = 1'b0;
      pc_q   = '0;
      alu_q  = '0;
      errors = 0;
    endfunction

    function logic [31:0] gpr_val(logic [4:0] idx);
      return (idx == '0) ? 32'h0 : gpr[idx];
    endfunction

    function bit word_known(logic [DMEM_AW-1:0] idx);
      return dmem_valid[idx];
    endfunction

    // data word a load would touch with the current register contents
    function logic [DMEM_AW-1:0] load_slot(logic [31:0] insn);
      logic [31:0] addr;
      addr = gpr_val(insn[25:21]) + {{16{insn[15]}}, insn[15:0]};
      return addr[DMEM_AW+1:2];
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    // run one accepted request through the shadow core
    function void note_request(action_t act, in_item_t req);
      out_item_t   res;
      logic [31:0] insn, imm, a, b, pc4, wdata;
      logic [5:0]  op;
      logic [4:0]  rs, rt, rd, dst;
      logic [2:0]  code;
      bit          jmp, ity, wen;
      res  = '0;
      insn = req.instruction;
      case (act)
        ACT_WRMEM: begin
          dmem[req.word_index]       = req.load_value;
          dmem_valid[req.word_index] = 1'b1;
        end
        ACT_RDMEM: res.read_value = dmem[req.word_index];
        ACT_RDREG: res.read_value = gpr_val(req.register_index);
        default: begin
          if (insn == HALT_WORD) begin
            res.halted = 1'b1;
          end else begin
            op  = insn[31:26];
            rs  = insn[25:21];
            rt  = insn[20:16];
            rd  = insn[15:11];
            imm = {{16{insn[15]}}, insn[15:0]};
            pc4 = pc_q + PC_STEP;
            jmp = (op == OP_J) || (op == OP_JAL);
            ity = (op != OP_RTYPE) && !jmp;
            if (op == OP_LW || op == OP_SW) code = ALU_ADD;
            else if (op == OP_RTYPE) code = insn[2:0];
            else code = op[2:0];
            dst = '0;
            if (op == OP_RTYPE) begin
              dst = rd;
            end else if (ity) begin
              dst = rt;
            end else begin
              rs = '0;
              rt = '0;
            end
            a = gpr_val(rs);
            b = ity ? imm : gpr_val(rt);
            // next pc: jump, taken branch or fall through
            if (jmp) begin
              pc_q = {pc4[31:28], insn[25:0], 2'b00};
            end else if (op == OP_BEQ && gpr_val(rs) == gpr_val(rt)) begin
              pc_q = pc4 + (imm << 2);
              res.branch_taken = 1'b1;
            end else begin
              pc_q = pc4;
            end
            // codes outside the list keep the old ALU result
            case (code)
              ALU_ADD: alu_q = a + b;
              ALU_SUB: alu_q = a - b;
              ALU_AND: alu_q = a & b;
              ALU_OR:  alu_q = a | b;
              ALU_NOR: alu_q = ~(a | b);
              default: ;
            endcase
            wdata = alu_q;
            if (op == OP_LW) wdata = dmem[alu_q[DMEM_AW+1:2]];
            if (op == OP_SW) begin
              dmem[alu_q[DMEM_AW+1:2]]       = gpr_val(rt);
              dmem_valid[alu_q[DMEM_AW+1:2]] = 1'b1;
            end
            // writeback, register zero drops it
            wen = !(op == OP_SW || op == OP_J || op == OP_BEQ);
            if (wen && dst != '0) begin
              gpr[dst]          = wdata;
              res.reg_written   = 1'b1;
              res.dest_register = dst;
              res.dest_value    = wdata;
            end
          end
        end
      endcase
      res.next_pc   = pc_q;
      res.alu_value = alu_q;
      pending_results.push_back(res);
    endfunction

    function void cmp(string name, logic [31:0] exp_v, logic [31:0] got_v);
      if (exp_v !== got_v) begin
        $error("%s: expected %h, got %h", name, exp_v, got_v);
        errors++;
      end
    endfunction

    // compare one accepted result with the oldest prediction
    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        $error("result with no prediction waiting: %h", got);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      cmp("next_pc", want.next_pc, got.next_pc);
      cmp("halted", 32'(want.halted), 32'(got.halted));
      cmp("alu_value", want.alu_value, got.alu_value);
      cmp("reg_written", 32'(want.reg_written), 32'(got.reg_written));
      cmp("dest_register", 32'(want.dest_register), 32'(got.dest_register));
      cmp("dest_value", want.dest_value, got.dest_value);
      cmp("branch_taken", 32'(want.branch_taken), 32'(got.branch_taken));
      cmp("read_value", want.read_value, got.read_value);
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic [1:0]       in_tuser = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  core_scoreboard     sb;
  logic [DMEM_AW-1:0] known_words[$];
  int                 send_idle_pct = 0;
  int                 stall_pct = 0;
  int                 stall_left = 0;

  mips_subset_single_cycle_core_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  // output stalls in bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
      out_tready <= 1'b0;
      stall_left = $urandom_range(0, 7);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // handshake seen at mid-cycle completes at the next rising edge
  always @(negedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_item_t'(out_tdata));
  end

  // request with random content in the fields the action ignores
  function automatic in_item_t filler();
    in_item_t req;
    req.instruction    = $urandom;
    req.word_index     = DMEM_AW'($urandom);
    req.load_value     = $urandom;
    req.register_index = 5'($urandom);
    req.pad            = '0;
    return req;
  endfunction

  function automatic logic [31:0] rtype(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
                                        logic [5:0] funct);
    return {OP_RTYPE, rs, rt, rd, 5'($urandom), funct};
  endfunction

  function automatic logic [31:0] itype(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                        logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  // mostly a few low registers so operands repeat and branches hit
  function automatic logic [4:0] pick_reg();
    return ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'($urandom_range(0, 7));
  endfunction

  function automatic logic [15:0] pick_imm();
    case ($urandom_range(0, 5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'hFFFF;
      3: return 16'($urandom_range(0, 15) * 4);
      default: return 16'($urandom);
    endcase
  endfunction

  // present one request, called at a rising edge, returns at its acceptance edge
  task automatic send(action_t act, in_item_t req);
    if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= req;
    in_tuser  <= act;
    do @(negedge clk); while (!in_tready);
    sb.note_request(act, req);
    @(posedge clk);
  endtask

  task automatic mem_write(logic [DMEM_AW-1:0] idx, logic [31:0] val);
    in_item_t req;
    req            = filler();
    req.word_index = idx;
    req.load_value = val;
    send(ACT_WRMEM, req);
    known_words.push_back(idx);
  endtask

  task automatic mem_read(logic [DMEM_AW-1:0] idx);
    in_item_t req;
    req            = filler();
    req.word_index = idx;
    send(ACT_RDMEM, req);
  endtask

  task automatic reg_read(logic [4:0] idx);
    in_item_t req;
    req                = filler();
    req.register_index = idx;
    send(ACT_RDREG, req);
  endtask

  // a load from a word never written gets that word preloaded first
  task automatic exec(logic [31:0] insn);
    in_item_t req;
    req = filler();
    req.instruction = insn;
    if (insn[31:26] == OP_LW && !sb.word_known(sb.load_slot(insn)))
      mem_write(sb.load_slot(insn), $urandom);
    send(ACT_EXEC, req);
  endtask

  // one random request of any kind
  task automatic random_request();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      mem_write(($urandom_range(0, 1) == 0) ? DMEM_AW'($urandom_range(0, 63))
                                            : DMEM_AW'($urandom), $urandom);
    end else if (pick < 14 && known_words.size() > 0) begin
      mem_read(known_words[$urandom_range(0, known_words.size() - 1)]);
    end else if (pick < 20) begin
      reg_read(5'($urandom));
    end else if (pick < 36) begin
      exec(rtype(pick_reg(), pick_reg(), pick_reg(), 6'($urandom)));
    end else if (pick < 55) begin
      exec(itype(6'($urandom_range(5, 63)), pick_reg(), pick_reg(), pick_imm()));
    end else if (pick < 65) begin
      exec(itype(OP_LW, pick_reg(), pick_reg(), pick_imm()));
    end else if (pick < 72) begin
      exec(itype(OP_SW, pick_reg(), pick_reg(), pick_imm()));
    end else if (pick < 82) begin
      exec(itype(OP_BEQ, pick_reg(), pick_reg(), pick_imm()));
    end else if (pick < 87) begin
      exec({($urandom_range(0, 1) == 0) ? OP_J : OP_JAL, 26'($urandom)});
    end else if (pick < 90) begin
      exec(HALT_WORD);
    end else begin
      exec($urandom);
    end
  endtask

  // run timeout
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // main sequence
  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (3) @(posedge clk);

    // directed: every ALU code, register zero, memory extremes, branches, jumps, halt
    reg_read(5'd31);
    exec(itype(6'd9, 5'd0, 5'd1, 16'h7FFF));
    exec(itype(6'd9, 5'd0, 5'd2, 16'h8000));
    exec(itype(6'd13, 5'd1, 5'd0, 16'h1234));
    exec(rtype(5'd1, 5'd2, 5'd3, 6'd33));
    exec(rtype(5'd1, 5'd2, 5'd4, 6'd35));
    exec(rtype(5'd1, 5'd2, 5'd5, 6'd36));
    exec(rtype(5'd1, 5'd2, 5'd6, 6'd37));
    exec(rtype(5'd1, 5'd2, 5'd7, 6'd39));
    exec(rtype(5'd1, 5'd2, 5'd8, 6'd0));
    exec(rtype(5'd3, 5'd4, 5'd9, 6'd42));
    exec(rtype(5'd3, 5'd4, 5'd10, 6'd38));
    exec(itype(6'd12, 5'd7, 5'd11, 16'hFFFF));
    exec(itype(6'd11, 5'd2, 5'd12, 16'h0001));
    mem_write('0, 32'hFFFF_FFFF);
    mem_write('1, 32'h0);
    mem_read('1);
    exec(itype(OP_SW, 5'd0, 5'd2, 16'd20));
    exec(itype(OP_LW, 5'd0, 5'd13, 16'd23));
    exec(itype(OP_LW, 5'd2, 5'd14, 16'h7FFC));
    exec(itype(OP_BEQ, 5'd1, 5'd1, 16'hFFFF));
    exec(itype(OP_BEQ, 5'd1, 5'd2, 16'h0003));
    exec({OP_J, 26'h3FF_FFFF});
    exec({OP_JAL, 26'h0});
    exec(HALT_WORD);
    reg_read(5'd14);

    // random: light idling, none, heavy idling after a drain, then none
    for (int i = 0; i < 800; i++) begin
      if (i == 0) begin
        send_idle_pct = 20;
        stall_pct     = 10;
      end else if (i == 250) begin
        send_idle_pct = 0;
        stall_pct     = 0;
      end else if (i == 400) begin
        in_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        send_idle_pct = 40;
        stall_pct     = 25;
      end else if (i == 650) begin
        send_idle_pct = 0;
        stall_pct     = 0;
      end
      random_request();
    end

    // drain and let any stray result show up
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- mips_subset_single_cycle_core_unit.f -----
hw/rtl/mscc_pkg.sv
hw/rtl/mscc_ram.sv
hw/rtl/mips_subset_single_cycle_core_unit.sv
hw/rtl/mscc_checker.sv
sim/tb.sv
